@@ src/pbpl_pkg.sv @@
// ---------------------------------------------------------------------------
// pbpl_pkg
// Shared constants for the page buffer pool with LRU replacement.
// ---------------------------------------------------------------------------
package pbpl_pkg;
   localparam logic [2:0] OP_GET       = 3'd0;
   localparam logic [2:0] OP_RELEASE   = 3'd1;
   localparam logic [2:0] OP_MARK      = 3'd2;
   localparam logic [2:0] OP_FLUSH     = 3'd3;
   localparam logic [2:0] OP_FLUSH_ALL = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_PINNED   = 2'd1;
   localparam logic [1:0] ST_RESERVED = 2'd2;

   localparam int PAGE_W = 32;
endpackage

@@ src/pbpl_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pbpl_ram
// Single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pbpl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ src/page_buffer_pool_lru.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// page_buffer_pool_lru
// Buffer pool frame tracker with LRU replacement. Tags live in a RAM; per-frame
// flags and ranks live in flops. One frame's tag is read per cycle.
// Get, release, mark dirty and flush page strobe their word after one tag read and
// victim compare per frame, a victim tag read and the update.
// A reserved id or an unknown code skips the scan and strobes straight from the update.
// Flush all strobes one word if nothing is dirty, else one word per dirty frame, each after its tag is prefetched.
// Throughput: one operation at a time; busy falls in the cycle carrying the last word.
// Reset clears all flags, ranks and the occupancy; the tag RAM needs no clear,
// since a tag is only used for a frame marked valid. Results cannot be stalled.
// ---------------------------------------------------------------------------
module page_buffer_pool_lru #(
   parameter int CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_page_number,
   input  wire logic        req_set_dirty,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_hit,
   output logic [3:0]       rsp_slot,
   output logic             rsp_load_request,
   output logic             rsp_write_back,
   output logic [31:0]      rsp_wb_tag,
   output logic [3:0]       rsp_write_frame,
   output logic             rsp_last
);
   import pbpl_pkg::*;

   localparam int IW = $clog2(CAPACITY);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DEC  = 3'd2;
   localparam logic [2:0] S_VTAG = 3'd3;
   localparam logic [2:0] S_EXEC = 3'd4;
   localparam logic [2:0] S_FALL = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        op_ff;
   logic [31:0]       page_ff;
   logic              sd_ff;
   logic [CAPACITY-1:0] valid_ff, dirty_ff, pinned_ff;
   logic [IW-1:0]     rank_ff [CAPACITY];
   logic [IW:0]       idx_ff;
   logic              rv_ff;
   logic [IW-1:0]     raddr_q;
   logic              found_ff;
   logic [IW-1:0]     fidx_ff;
   logic              have_vic_ff;
   logic [IW-1:0]     vic_ff, vic_rank_ff;
   // flush-all tag prefetch
   logic              fa_primed_ff;

   logic              wr_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [31:0]       wr_data, rd_data;

   pbpl_ram #(.WIDTH(PAGE_W), .DEPTH(CAPACITY)) u_tag (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // free frame: narrow flag logic; LRU victim is picked during the scan
   logic              have_free, have_vic;
   logic [IW-1:0]     free_idx, vic_idx;
   always_comb begin
      have_free = 1'b0; free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            have_free = 1'b1; free_idx = IW'(i);
         end
      end
   end
   assign have_vic = have_vic_ff;
   assign vic_idx  = vic_ff;

   logic              any_dirty;
   logic [IW-1:0]     dirty_idx;
   always_comb begin
      any_dirty = 1'b0; dirty_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (valid_ff[i] && dirty_ff[i]) begin
            any_dirty = 1'b1; dirty_idx = IW'(i);
         end
      end
   end
   logic [CAPACITY-1:0] dirty_next;
   always_comb begin
      dirty_next = dirty_ff;
      dirty_next[dirty_idx] = 1'b0;
   end
   logic more_dirty;
   assign more_dirty = |(dirty_next & valid_ff);

   // flush all stays until the word for the last dirty frame is sent
   logic fall_exit;
   assign fall_exit = (state_ff == S_FALL) && (!any_dirty || (fa_primed_ff && !more_dirty));

   assign busy = (state_ff != S_IDLE);
   logic accept;
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            if (req_operation == OP_FLUSH_ALL) state_in = S_FALL;
            else if (req_operation > OP_FLUSH_ALL || req_page_number == '0) state_in = S_EXEC;
            else state_in = S_SCAN;
         end
         S_SCAN: if (idx_ff == (IW+1)'(CAPACITY - 1)) state_in = S_DEC;
         S_DEC:  state_in = S_VTAG;
         S_VTAG: state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         S_FALL: if (fall_exit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rd_addr = idx_ff[IW-1:0];
      if (state_ff == S_DEC || state_ff == S_VTAG) rd_addr = vic_idx;
      else if (state_ff == S_FALL) rd_addr = dirty_idx;
   end

   // flush all reads the tag of the frame ahead of its word: use a prefetch stage
   logic [31:0] tag_now;
   assign tag_now = rd_data;

   logic [IW-1:0] target;
   logic          get_miss_ok;
   logic          vic_wb;
   logic [IW-1:0] slot;
   assign get_miss_ok = have_free || have_vic;
   assign slot = have_free ? free_idx : vic_idx;
   assign vic_wb = !have_free && dirty_ff[vic_idx];
   assign target = fidx_ff;

   assign wr_en   = (state_ff == S_EXEC) && op_ff == OP_GET && page_ff != '0 &&
                    !found_ff && get_miss_ok;
   assign wr_addr = slot;
   assign wr_data = page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0; dirty_ff <= '0; pinned_ff <= '0;
         for (int i = 0; i < CAPACITY; i++) rank_ff[i] <= '0;
         idx_ff <= '0; rv_ff <= 1'b0; found_ff <= 1'b0; fa_primed_ff <= 1'b0;
         have_vic_ff <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= 1'b0;
         rv_ff      <= 1'b0;
         if (accept) begin
            op_ff <= req_operation; page_ff <= req_page_number; sd_ff <= req_set_dirty;
            idx_ff <= '0; found_ff <= 1'b0; fa_primed_ff <= 1'b0;
            have_vic_ff <= 1'b0;
         end
         if (state_ff == S_SCAN) begin
            rv_ff   <= 1'b1;
            raddr_q <= idx_ff[IW-1:0];
            idx_ff  <= idx_ff + 1'b1;
            if (valid_ff[idx_ff[IW-1:0]] && !pinned_ff[idx_ff[IW-1:0]] &&
                (!have_vic_ff || rank_ff[idx_ff[IW-1:0]] > vic_rank_ff)) begin
               have_vic_ff <= 1'b1;
               vic_ff      <= idx_ff[IW-1:0];
               vic_rank_ff <= rank_ff[idx_ff[IW-1:0]];
            end
         end
         if (rv_ff && valid_ff[raddr_q] && tag_now == page_ff && !found_ff) begin
            found_ff <= 1'b1; fidx_ff <= raddr_q;
         end
         if (state_ff == S_EXEC) begin
            rsp_strobe <= 1'b1; rsp_last <= 1'b1;
            rsp_status <= ST_OK; rsp_hit <= 1'b0; rsp_slot <= '0;
            rsp_load_request <= 1'b0; rsp_write_back <= 1'b0;
            rsp_wb_tag <= '0; rsp_write_frame <= '0;
            if (op_ff > OP_FLUSH_ALL) begin
            end else if (page_ff == '0) begin
               rsp_status <= ST_RESERVED;
            end else if (op_ff == OP_GET) begin
               if (found_ff) begin
                  rsp_hit <= 1'b1; rsp_slot <= 4'(target);
                  pinned_ff[target] <= 1'b1;
                  if (!pinned_ff[target]) begin
                     for (int i = 0; i < CAPACITY; i++)
                        if (valid_ff[i] && rank_ff[i] < rank_ff[target])
                           rank_ff[i] <= rank_ff[i] + 1'b1;
                     rank_ff[target] <= '0;
                  end
               end else if (!get_miss_ok) begin
                  rsp_status <= ST_PINNED;
               end else begin
                  // evict (ranks above victim shift down) then age all, net effect:
                  for (int i = 0; i < CAPACITY; i++)
                     if (valid_ff[i] && IW'(i) != slot &&
                         (have_free || rank_ff[i] < rank_ff[slot]))
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                  rank_ff[slot]   <= '0;
                  valid_ff[slot]  <= 1'b1;
                  dirty_ff[slot]  <= 1'b0;
                  pinned_ff[slot] <= 1'b1;
                  rsp_slot <= 4'(slot); rsp_load_request <= 1'b1;
                  if (vic_wb) begin
                     rsp_write_back <= 1'b1; rsp_wb_tag <= tag_now;
                     rsp_write_frame <= 4'(vic_idx);
                  end
               end
            end else if (found_ff) begin
               if (op_ff == OP_RELEASE) begin
                  if (sd_ff) dirty_ff[target] <= 1'b1;
                  pinned_ff[target] <= 1'b0;
                  for (int i = 0; i < CAPACITY; i++)
                     if (valid_ff[i] && rank_ff[i] < rank_ff[target])
                        rank_ff[i] <= rank_ff[i] + 1'b1;
                  rank_ff[target] <= '0;
               end else if (op_ff == OP_MARK) begin
                  dirty_ff[target] <= 1'b1;
               end else if (op_ff == OP_FLUSH && dirty_ff[target]) begin
                  dirty_ff[target] <= 1'b0;
                  rsp_write_back <= 1'b1; rsp_wb_tag <= page_ff;
                  rsp_write_frame <= 4'(target);
               end
            end
         end
         if (state_ff == S_FALL) begin
            fa_primed_ff <= any_dirty && !fa_primed_ff;
            raddr_q <= dirty_idx;
            if (!any_dirty) begin
               rsp_strobe <= 1'b1; rsp_last <= 1'b1; rsp_status <= ST_OK;
               rsp_hit <= 1'b0; rsp_slot <= '0; rsp_load_request <= 1'b0;
               rsp_write_back <= 1'b0; rsp_wb_tag <= '0; rsp_write_frame <= '0;
            end else if (fa_primed_ff && raddr_q == dirty_idx) begin
               rsp_strobe <= 1'b1; rsp_last <= !more_dirty; rsp_status <= ST_OK;
               rsp_hit <= 1'b0; rsp_slot <= '0; rsp_load_request <= 1'b0;
               rsp_write_back <= 1'b1; rsp_wb_tag <= tag_now;
               rsp_write_frame <= 4'(dirty_idx);
               dirty_ff <= dirty_next;
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_load_request |-> rsp_status == ST_OK && !rsp_hit)
      else $error("load request with bad status");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_RESERVED |-> !rsp_write_back && !rsp_load_request)
      else $error("reserved id caused action");
   assert property (@(posedge clock) disable iff (reset)
      $past(accept && !reset) |-> busy)
      else $error("accept did not raise busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_write_back |-> rsp_wb_tag != '0)
      else $error("write back of empty page");
endmodule
`default_nettype wire
